// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    localparam int IDX_W  = 11;
    localparam int DATA_W = 16;
    localparam int CHAR_W = 8;
    localparam int REQ_W  = 2;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'd127;

    localparam logic [CHAR_W-1:0] RESET_COLOUR = 8'h0F;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_RESP
    } tcw_state_t;

endpackage

// ===== rtl/tcw_screen_ram.sv =====
module tcw_screen_ram #(
    parameter int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [tcw_pkg::DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [tcw_pkg::DATA_W-1:0] rd_data
);
    import tcw_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/text_console_writer_top.sv =====
// text console engine: a COLUMNS x ROWS screen of 16-bit cells (attribute high
// byte, character low byte) in one single-port-write RAM, plus a cursor in registers.
// input channel (in_valid/in_stall): req_type put, read or clear; char_code
// and cell_index ride along. every accepted beat gives exactly one result beat
// on the output channel (out_valid/out_stall) carrying cursor_pos and
// cell_data. text_colour is written through cfg_valid/cfg_ready, which is
// always ready; write it only while the block is idle.
// a plain put or an ignored byte goes from accept to ST_RESP, a read passes
// through ST_READ first; ST_RESP loads the output register once it is free.
// a put that runs off the bottom row scrolls the screen: ST_COPY copies each
// row one row up through the RAM port, then ST_BLANK blanks the last row.
// a clear homes the cursor and blanks every cell in ST_BLANK. one item is
// handled at a time; in_stall stays high until its result is loaded into
// the output register.
// after reset the RAM is swept to blank cells with attribute 0x0F, one cell
// per cycle, with in_stall high; config writes are taken.
// a stalled result holds in the output register; the next item is accepted
// but its result waits until the register frees up.
module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tcw_pkg::REQ_W-1:0]   req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcw_pkg::IDX_W-1:0]   cell_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tcw_pkg::IDX_W-1:0]   cursor_pos,
    output logic [tcw_pkg::DATA_W-1:0]  cell_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]  text_colour
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int WIDE_W = IDX_W + ADDR_W;

    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [WIDE_W-1:0] CELLS_W   = WIDE_W'(CELLS);

    tcw_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [DATA_W-1:0] resp_data_reg, resp_data_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [CHAR_W-1:0] text_colour_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  cursor_pos_reg;
    logic [DATA_W-1:0] cell_data_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_wa;
    logic [DATA_W-1:0] ram_wd;
    logic [ADDR_W-1:0] ram_ra;
    logic [DATA_W-1:0] ram_rd_data;

    logic              out_load;
    logic              row_adv;
    logic [ADDR_W-1:0] cur_lin;
    logic [WIDE_W-1:0] cur_wide;
    logic [WIDE_W-1:0] idx_wide;
    logic              idx_ok;
    logic              on_last_row;
    logic              printable;

    assign cur_lin     = base_reg + ADDR_W'(col_reg);
    assign cur_wide    = WIDE_W'(cur_lin);
    assign idx_wide    = WIDE_W'(cell_index);
    assign idx_ok      = idx_wide < CELLS_W;
    assign on_last_row = base_reg == LAST_BASE;
    assign printable   = (char_code >= CH_PRINT_LO) && (char_code <= CH_PRINT_HI);

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (ram_ra),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        base_next      = base_reg;
        col_next       = col_reg;
        resp_data_next = resp_data_reg;
        rd_ok_next     = rd_ok_reg;
        ram_we         = 1'b0;
        ram_wa         = cnt_reg;
        ram_wd         = {text_colour_reg, CH_SPACE};
        ram_ra         = cnt_reg + COLS_A;
        out_load       = 1'b0;
        row_adv        = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we = 1'b1;
                ram_wd = {RESET_COLOUR, CH_SPACE};
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                ram_ra = idx_wide[ADDR_W-1:0];
                if (in_valid)
                begin
                    resp_data_next = '0;
                    state_next     = ST_RESP;
                    case (req_type)
                        REQ_PUT:
                        begin
                            if (char_code == CH_NEWLINE)
                            begin
                                col_next = '0;
                                row_adv  = 1'b1;
                            end
                            else if (char_code == CH_BACKSPACE)
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next = col_reg - 1'b1;
                                    ram_we   = 1'b1;
                                    ram_wa   = cur_lin - 1'b1;
                                end
                            end
                            else if (printable)
                            begin
                                ram_we = 1'b1;
                                ram_wa = cur_lin;
                                ram_wd = {text_colour_reg, char_code};
                                if (col_reg == COL_LAST)
                                begin
                                    col_next = '0;
                                    row_adv  = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                        end
                        REQ_READ:
                        begin
                            rd_ok_next = idx_ok;
                            state_next = ST_READ;
                        end
                        REQ_CLEAR:
                        begin
                            base_next  = '0;
                            col_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_BLANK;
                        end
                        default:
                        begin
                        end
                    endcase
                    // moving past the last row scrolls instead of advancing
                    if (row_adv)
                    begin
                        if (on_last_row)
                        begin
                            cnt_next   = '0;
                            state_next = ST_COPY;
                        end
                        else
                        begin
                            base_next = base_reg + COLS_A;
                        end
                    end
                end
            end

            ST_READ:
            begin
                resp_data_next = rd_ok_reg ? ram_rd_data : '0;
                state_next     = ST_RESP;
            end

            ST_COPY:
            begin
                // read runs one cell ahead, write lands one row up
                ram_ra = cnt_reg + COLS_A;
                ram_we = cnt_reg != '0;
                ram_wa = cnt_reg - 1'b1;
                ram_wd = ram_rd_data;
                if (cnt_reg == LAST_BASE)
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_BLANK:
            begin
                ram_we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            cnt_reg         <= '0;
            base_reg        <= '0;
            col_reg         <= '0;
            text_colour_reg <= RESET_COLOUR;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            base_reg  <= base_next;
            col_reg   <= col_next;
            if (cfg_valid && cfg_ready)
            begin
                text_colour_reg <= text_colour;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        resp_data_reg <= resp_data_next;
        rd_ok_reg     <= rd_ok_next;
        if (out_load)
        begin
            cursor_pos_reg <= cur_wide[IDX_W-1:0];
            cell_data_reg  <= resp_data_reg;
        end
    end

    assign in_stall   = state_reg != ST_IDLE;
    assign out_valid  = out_valid_reg;
    assign cursor_pos = cursor_pos_reg;
    assign cell_data  = cell_data_reg;
    assign cfg_ready  = 1'b1;

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    a_scroll_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COPY |-> base_reg == LAST_BASE && col_reg == '0)
        else $error("scroll copy with cursor off the last row");

    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_LAST)
        else $error("cursor column past row end");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside response state");

endmodule
